[hdl/rrts_pkg.sv]
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

    localparam int REQ_W       = 2;
    localparam int SP_PORT_W   = 16;
    localparam int LOCK_W      = 2;
    localparam int SLOT_PORT_W = 4;
    localparam int STATUS_W    = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE  = 2'd0,
        REQ_SELECT  = 2'd1,
        REQ_ACQUIRE = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD     = 3'd4
    } t_status_e;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_PURGE_RD = 8'b0000_0100,
        S_PURGE_WR = 8'b0000_1000,
        S_POP      = 8'b0001_0000,
        S_SP       = 8'b0010_0000,
        S_REL      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state_e;

endpackage

[hdl/rrts_req_if.sv]
// Request channel of the scheduler: valid, ready and one request word.
interface rrts_req_if;
    import rrts_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [SP_PORT_W-1:0] stack_ptr;
    logic [LOCK_W-1:0]   lock_id;

    modport source (output valid, output req_type, output stack_ptr, output lock_id,
                    input ready);
    modport sink (input valid, input req_type, input stack_ptr, input lock_id,
                  output ready);
endinterface

[hdl/rrts_res_if.sv]
// Result channel of the scheduler: valid, ready and one result word.
interface rrts_res_if;
    import rrts_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SP_PORT_W-1:0]   next_sp;
    logic [SLOT_PORT_W-1:0] task_slot;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output next_sp, output task_slot, output status,
                    input ready);
    modport sink (input valid, input next_sp, input task_slot, input status,
                  output ready);
endinterface

[hdl/rrts_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
module rrts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/round_robin_task_scheduler_with_locks.sv]
// Round-robin task scheduler with lock wait queues. Each request word (create, select,
// acquire, release) yields exactly one result word. The saved stack pointers live in one
// RAM and all queue rings (the ready queue and one wait queue per lock) share a second
// RAM; in-use, blocked and held flags, queue heads and counts are flip-flops. One request
// is handled at a time. Create and acquire go from S_EXEC to S_DONE, which loads the
// result register; release passes through S_REL (a ring read) and select through S_POP
// and S_SP (a ring read for the dequeue, then a stack-pointer read). A select that
// terminates a blocked task first compacts that task's lock wait queue: each entry is
// read, and every entry but the terminating task's is written back through the ring RAM.
// The result register frees the input side: a new request is accepted while the last
// result still waits for its consumer, and the block only stalls when a second result
// is ready before the first was taken. Stack pointers are kept to SP_WIDTH bits.
module round_robin_task_scheduler_with_locks #(
    parameter int MAX_TASKS = 16,
    parameter int NUM_LOCKS = 4,
    parameter int SP_WIDTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrts_req_if.sink  i_req,
    rrts_res_if.source o_res
);
    import rrts_pkg::*;

    // Slot index, queue count, queue select and lock index widths.
    localparam int SW  = $clog2(MAX_TASKS);
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int NQ  = NUM_LOCKS + 1;
    localparam int QW  = $clog2(NQ);
    localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int RAW = QW + SW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

    // Next slot position in a ring of MAX_TASKS entries.
    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
        logic [SW-1:0] q;
        if (p == SW'(MAX_TASKS - 1)) begin
            q = '0;
        end else begin
            q = p + SW'(1);
        end
        return q;
    endfunction

    // Tail position of a ring: head plus count, modulo MAX_TASKS.
    function automatic logic [SW-1:0] tail_pos(input logic [SW-1:0] h,
                                               input logic [CW-1:0] c);
        logic [SW:0] s;
        s = {1'b0, h} + (SW+1)'(c);
        if (s >= (SW+1)'(MAX_TASKS)) begin
            s = s - (SW+1)'(MAX_TASKS);
        end
        return s[SW-1:0];
    endfunction

    t_state_e r_state, n_state;

    // Latched request.
    t_req_e              r_req_type;
    logic [SP_WIDTH-1:0] r_sp;
    logic [LOCK_W-1:0]   r_lk;

    // Scheduler state in flip-flops.
    logic [MAX_TASKS-1:0] r_in_use, n_in_use;
    logic [MAX_TASKS-1:0] r_blocked, n_blocked;
    logic [NUM_LOCKS-1:0] r_held, n_held;
    logic [SW-1:0]        r_head [NQ];
    logic [SW-1:0]        n_head [NQ];
    logic [CW-1:0]        r_cnt [NQ];
    logic [CW-1:0]        n_cnt [NQ];
    logic                 r_run_valid, n_run_valid;
    logic [SW-1:0]        r_run_slot, n_run_slot;
    logic [LW-1:0]        r_run_lock, n_run_lock;

    // Dequeue and purge bookkeeping.
    logic [SW-1:0] r_pop_slot, n_pop_slot;
    logic          r_bypass, n_bypass;
    logic [SW-1:0] r_prd, n_prd;
    logic [SW-1:0] r_pwr, n_pwr;
    logic [CW-1:0] r_pi, n_pi;
    logic [CW-1:0] r_kept, n_kept;

    // Pending result and the output register.
    logic [SP_WIDTH-1:0] r_res_sp, n_res_sp;
    logic [SW-1:0]       r_res_slot, n_res_slot;
    t_status_e           r_res_status, n_res_status;
    logic                r_out_valid;
    logic [SP_PORT_W-1:0]   r_out_sp;
    logic [SLOT_PORT_W-1:0] r_out_slot;
    logic [STATUS_W-1:0]    r_out_status;

    // RAM ports.
    logic                w_rw_we, w_rr_re, w_sw_we, w_sr_re;
    logic [RAW-1:0]      w_rw_addr, w_rr_addr;
    logic [SW-1:0]       w_rw_data, w_rr_data;
    logic [SW-1:0]       w_sw_addr, w_sr_addr;
    logic [SP_WIDTH-1:0] w_sw_data, w_sr_data;

    logic          w_accept;
    logic          w_out_load;
    logic          w_do_sel;
    logic          w_free_found;
    logic [SW-1:0] w_free_slot;
    logic [LW-1:0] w_lk;
    logic [QW-1:0] w_lq;
    logic [QW-1:0] w_pq;
    logic          w_lk_bad;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    assign w_lk     = LW'(r_lk);
    assign w_lq     = QW'(w_lk) + QW'(1);
    assign w_pq     = QW'(r_run_lock) + QW'(1);
    assign w_lk_bad = (int'(r_lk) >= NUM_LOCKS);

    // Lowest free slot for create.
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = SW'(i);
            end
        end
    end

    rrts_ram #(.DEPTH(2 ** RAW), .WIDTH(SW)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (w_rw_we),
        .i_waddr (w_rw_addr),
        .i_wdata (w_rw_data),
        .i_re    (w_rr_re),
        .i_raddr (w_rr_addr),
        .o_rdata (w_rr_data)
    );

    rrts_ram #(.DEPTH(MAX_TASKS), .WIDTH(SP_WIDTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_sw_we),
        .i_waddr (w_sw_addr),
        .i_wdata (w_sw_data),
        .i_re    (w_sr_re),
        .i_raddr (w_sr_addr),
        .o_rdata (w_sr_data)
    );

    // Request sequencer. Every state does at most one ring write and one ring read.
    always_comb begin
        logic [CW-1:0] c;
        logic [SW-1:0] s;

        n_state      = r_state;
        n_in_use     = r_in_use;
        n_blocked    = r_blocked;
        n_held       = r_held;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_run_valid  = r_run_valid;
        n_run_slot   = r_run_slot;
        n_run_lock   = r_run_lock;
        n_pop_slot   = r_pop_slot;
        n_bypass     = r_bypass;
        n_prd        = r_prd;
        n_pwr        = r_pwr;
        n_pi         = r_pi;
        n_kept       = r_kept;
        n_res_sp     = r_res_sp;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        w_rw_we      = 1'b0;
        w_rw_addr    = '0;
        w_rw_data    = '0;
        w_rr_re      = 1'b0;
        w_rr_addr    = '0;
        w_sw_we      = 1'b0;
        w_sw_addr    = '0;
        w_sw_data    = '0;
        w_sr_re      = 1'b0;
        w_sr_addr    = '0;
        w_do_sel     = 1'b0;
        c            = '0;
        s            = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_sp     = '0;
                n_res_slot   = '0;
                n_res_status = ST_OK;
                n_state      = S_DONE;
                unique case (r_req_type)
                    REQ_CREATE: begin
                        if (!w_free_found) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_in_use[w_free_slot]  = 1'b1;
                            n_blocked[w_free_slot] = 1'b0;
                            w_sw_we   = 1'b1;
                            w_sw_addr = w_free_slot;
                            w_sw_data = r_sp;
                            if (r_cnt[0] < CNT_MAX) begin
                                w_rw_we   = 1'b1;
                                w_rw_addr = {QW'(0), tail_pos(r_head[0], r_cnt[0])};
                                w_rw_data = w_free_slot;
                                n_cnt[0]  = r_cnt[0] + CW'(1);
                            end
                            n_res_slot = w_free_slot;
                        end
                    end
                    REQ_SELECT: begin
                        if (r_sp != '0 && !r_run_valid) begin
                            n_res_status = ST_BAD;
                        end else if (r_sp == '0 && r_run_valid && r_blocked[r_run_slot]) begin
                            // The terminating task still sits in one wait queue.
                            n_prd   = r_head[w_pq];
                            n_pwr   = r_head[w_pq];
                            n_pi    = '0;
                            n_kept  = '0;
                            n_state = S_PURGE_RD;
                        end else begin
                            w_do_sel = 1'b1;
                        end
                    end
                    REQ_ACQUIRE: begin
                        if (w_lk_bad) begin
                            n_res_status = ST_BAD;
                        end else if (!r_held[w_lk]) begin
                            n_held[w_lk] = 1'b1;
                        end else if (!r_run_valid || r_blocked[r_run_slot]) begin
                            n_res_status = ST_BAD;
                        end else begin
                            n_blocked[r_run_slot] = 1'b1;
                            n_run_lock            = w_lk;
                            if (r_cnt[w_lq] < CNT_MAX) begin
                                w_rw_we     = 1'b1;
                                w_rw_addr   = {w_lq, tail_pos(r_head[w_lq], r_cnt[w_lq])};
                                w_rw_data   = r_run_slot;
                                n_cnt[w_lq] = r_cnt[w_lq] + CW'(1);
                            end
                            n_res_status = ST_BLOCKED;
                        end
                    end
                    REQ_RELEASE: begin
                        if (w_lk_bad) begin
                            n_res_status = ST_BAD;
                        end else if (r_cnt[w_lq] == '0) begin
                            n_held[w_lk] = 1'b0;
                        end else begin
                            w_rr_re      = 1'b1;
                            w_rr_addr    = {w_lq, r_head[w_lq]};
                            n_head[w_lq] = wrap_inc(r_head[w_lq]);
                            n_cnt[w_lq]  = r_cnt[w_lq] - CW'(1);
                            n_state      = S_REL;
                        end
                    end
                    default: begin
                        n_res_status = ST_BAD;
                    end
                endcase
            end
            S_PURGE_RD: begin
                if (r_pi == r_cnt[w_pq]) begin
                    n_cnt[w_pq] = r_kept;
                    w_do_sel    = 1'b1;
                end else begin
                    w_rr_re   = 1'b1;
                    w_rr_addr = {w_pq, r_prd};
                    n_state   = S_PURGE_WR;
                end
            end
            S_PURGE_WR: begin
                // Writes trail reads, so a compacted entry never overwrites an unread one.
                if (w_rr_data != r_run_slot) begin
                    w_rw_we   = 1'b1;
                    w_rw_addr = {w_pq, r_pwr};
                    w_rw_data = w_rr_data;
                    n_pwr     = wrap_inc(r_pwr);
                    n_kept    = r_kept + CW'(1);
                end
                n_prd   = wrap_inc(r_prd);
                n_pi    = r_pi + CW'(1);
                n_state = S_PURGE_RD;
            end
            S_POP: begin
                s           = r_bypass ? r_pop_slot : w_rr_data;
                n_run_valid = 1'b1;
                n_run_slot  = s;
                n_pop_slot  = s;
                w_sr_re     = 1'b1;
                w_sr_addr   = s;
                n_state     = S_SP;
            end
            S_SP: begin
                n_res_sp     = w_sr_data;
                n_res_slot   = r_pop_slot;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_REL: begin
                n_blocked[w_rr_data] = 1'b0;
                if (!(r_run_valid && r_run_slot == w_rr_data) && r_cnt[0] < CNT_MAX) begin
                    w_rw_we   = 1'b1;
                    w_rw_addr = {QW'(0), tail_pos(r_head[0], r_cnt[0])};
                    w_rw_data = w_rr_data;
                    n_cnt[0]  = r_cnt[0] + CW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Body of select: retire or requeue the running task, then dequeue the next one.
        if (w_do_sel) begin
            c = r_cnt[0];
            if (r_sp == '0) begin
                if (r_run_valid) begin
                    n_in_use[r_run_slot]  = 1'b0;
                    n_blocked[r_run_slot] = 1'b0;
                end
            end else begin
                w_sw_we   = 1'b1;
                w_sw_addr = r_run_slot;
                w_sw_data = r_sp;
                if (!r_blocked[r_run_slot] && r_cnt[0] < CNT_MAX) begin
                    w_rw_we   = 1'b1;
                    w_rw_addr = {QW'(0), tail_pos(r_head[0], r_cnt[0])};
                    w_rw_data = r_run_slot;
                    c         = r_cnt[0] + CW'(1);
                end
            end
            n_run_valid = 1'b0;
            n_bypass    = 1'b0;
            if (c == '0) begin
                n_res_sp     = '0;
                n_res_slot   = '0;
                n_res_status = ST_EMPTY;
                n_cnt[0]     = '0;
                n_state      = S_DONE;
            end else begin
                if (r_cnt[0] == '0) begin
                    // The queue was empty: the entry written now is the one dequeued.
                    n_bypass   = 1'b1;
                    n_pop_slot = r_run_slot;
                end else begin
                    w_rr_re   = 1'b1;
                    w_rr_addr = {QW'(0), r_head[0]};
                end
                n_head[0] = wrap_inc(r_head[0]);
                n_cnt[0]  = c - CW'(1);
                n_state   = S_POP;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_blocked   <= '0;
            r_held      <= '0;
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                r_head[q] <= '0;
                r_cnt[q]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_blocked   <= n_blocked;
            r_held      <= n_held;
            r_run_valid <= n_run_valid;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= t_req_e'(i_req.req_type);
            r_sp       <= SP_WIDTH'(i_req.stack_ptr);
            r_lk       <= i_req.lock_id;
        end
        r_run_slot   <= n_run_slot;
        r_run_lock   <= n_run_lock;
        r_pop_slot   <= n_pop_slot;
        r_bypass     <= n_bypass;
        r_prd        <= n_prd;
        r_pwr        <= n_pwr;
        r_pi         <= n_pi;
        r_kept       <= n_kept;
        r_res_sp     <= n_res_sp;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        if (w_out_load) begin
            r_out_sp     <= SP_PORT_W'(r_res_sp);
            r_out_slot   <= SLOT_PORT_W'(r_res_slot);
            r_out_status <= r_res_status;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.next_sp   = r_out_sp;
    assign o_res.task_slot = r_out_slot;
    assign o_res.status    = r_out_status;

    // The running task always owns its slot.
    a_run_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> r_in_use[r_run_slot])
        else $error("running task has a free slot");

    // Only slots in use can be blocked.
    a_blocked_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blocked & ~r_in_use) == '0)
        else $error("blocked flag on a free slot");

    // Work on a request starts only after a request word was accepted.
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(w_accept))
        else $error("request executed without an accepted word");
endmodule

[sim/tb.sv]
// Self-checking bench for the round-robin task scheduler with lock wait queues.
`timescale 1ns / 1ps

module tb;
    import rrts_pkg::*;

    localparam int NSLOTS   = 16;
    localparam int NLOCKS   = 4;
    localparam int N_RANDOM = 450;

    // One result word of the scheduler, as the checker sees it.
    typedef struct packed {
        logic [15:0]      sp;
        logic [3:0]       slot;
        logic [2:0]       status;
    } t_outcome;

    // A directed row: the request, and whether a hand-typed result is checked too.
    typedef struct packed {
        t_req_e      req;
        logic [15:0] sp;
        logic [1:0]  lock;
        logic        typed;
        t_outcome    want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rrts_req_if req_ch ();
    rrts_res_if res_ch ();

    round_robin_task_scheduler_with_locks DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous cap on the whole run, even when the consumer stalls and a terminate
    // compacts a full wait queue.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: task table, ready queue and lock wait queues.
    // ------------------------------------------------------------------
    logic [15:0] sh_stack   [NSLOTS];
    logic        sh_used    [NSLOTS];
    logic        sh_blocked [NSLOTS];
    logic [3:0]  sh_ready   [$];
    logic        sh_held    [NLOCKS];
    logic [3:0]  sh_waiters [NLOCKS][$];
    logic        sh_running;
    logic [3:0]  sh_cur;

    t_outcome    pending_results [$];
    int          mismatches;

    // Typed expectations for directed rows, in the order the rows were accepted.
    logic        typed_flag [$];
    t_outcome    typed_want [$];

    // Advance the shadow by one request and return the result word it should give.
    function automatic t_outcome schedule_step(t_req_e req, logic [15:0] sp, logic [1:0] lk);
        t_outcome r;
        int       s;
        logic     hit;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_CREATE: begin
                hit = 1'b0;
                for (s = 0; s < NSLOTS && !hit; s++) begin
                    if (!sh_used[s]) begin
                        hit = 1'b1;
                        sh_used[s]    = 1'b1;
                        sh_blocked[s] = 1'b0;
                        sh_stack[s]   = sp;
                        sh_ready.push_back(4'(s));
                        r.slot = 4'(s);
                    end
                end
                if (!hit) r.status = ST_FULL;
            end
            REQ_SELECT: begin
                if (sp != 0 && !sh_running) begin
                    r.status = ST_BAD;
                end else begin
                    if (sp == 0) begin
                        if (sh_running) begin
                            // A terminated task leaves every wait queue it sits in.
                            if (sh_blocked[sh_cur]) begin
                                for (int l = 0; l < NLOCKS; l++) begin
                                    for (int i = sh_waiters[l].size() - 1; i >= 0; i--)
                                        if (sh_waiters[l][i] == sh_cur)
                                            sh_waiters[l].delete(i);
                                end
                            end
                            sh_used[sh_cur]    = 1'b0;
                            sh_blocked[sh_cur] = 1'b0;
                        end
                    end else begin
                        sh_stack[sh_cur] = sp;
                        if (!sh_blocked[sh_cur]) sh_ready.push_back(sh_cur);
                    end
                    sh_running = 1'b0;
                    if (sh_ready.size() > 0) begin
                        sh_cur     = sh_ready.pop_front();
                        sh_running = 1'b1;
                        r.sp       = sh_stack[sh_cur];
                        r.slot     = sh_cur;
                    end else begin
                        r.status = ST_EMPTY;
                    end
                end
            end
            REQ_ACQUIRE: begin
                if (!sh_held[lk]) begin
                    sh_held[lk] = 1'b1;
                end else if (!sh_running || sh_blocked[sh_cur]) begin
                    r.status = ST_BAD;
                end else begin
                    sh_blocked[sh_cur] = 1'b1;
                    sh_waiters[lk].push_back(sh_cur);
                    r.status = ST_BLOCKED;
                end
            end
            default: begin
                if (sh_waiters[lk].size() > 0) begin
                    s = sh_waiters[lk].pop_front();
                    sh_blocked[s] = 1'b0;
                    // The running task is woken in place; its next select requeues it.
                    if (!(sh_running && sh_cur == 4'(s))) sh_ready.push_back(4'(s));
                end else begin
                    sh_held[lk] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("MISMATCH %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Request source: bursts of offered words separated by random gaps.
    // ------------------------------------------------------------------
    t_row   directed [$];
    int     burst_left;
    logic   sending_done;

    // Pick a request that exercises the deeper states most of the time.
    function automatic t_row random_request();
        t_row w;
        int   pick;
        w = '0;
        pick = $urandom_range(0, 99);
        w.lock = 2'($urandom_range(0, 3));
        if (pick < 22)      w.req = REQ_CREATE;
        else if (pick < 60) w.req = REQ_SELECT;
        else if (pick < 80) w.req = REQ_ACQUIRE;
        else                w.req = REQ_RELEASE;
        w.sp = 16'($urandom);
        // Terminations keep the table from staying full.
        if (w.req == REQ_SELECT && $urandom_range(0, 5) == 0) w.sp = 16'h0000;
        return w;
    endfunction

    task automatic send_word(t_row w);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= w.req;
        req_ch.stack_ptr <= w.sp;
        req_ch.lock_id   <= w.lock;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(schedule_step(w.req, w.sp, w.lock));
        typed_flag.push_back(w.typed);
        typed_want.push_back(w.want);
        // Idle between bursts; within a burst valid simply stays high.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic t_row row(t_req_e q, logic [15:0] sp, logic [1:0] lk,
                                 logic typed, logic [15:0] wsp, logic [3:0] wslot,
                                 t_status_e wst);
        t_row w;
        w.req = q; w.sp = sp; w.lock = lk; w.typed = typed;
        w.want.sp = wsp; w.want.slot = wslot; w.want.status = wst;
        return w;
    endfunction

    initial begin
        t_row w;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_CREATE;
        req_ch.stack_ptr = '0;
        req_ch.lock_id   = '0;
        sending_done     = 1'b0;
        burst_left       = 0;
        mismatches       = 0;
        sh_running       = 1'b0;
        sh_cur           = '0;
        for (int s = 0; s < NSLOTS; s++) begin
            sh_used[s] = 1'b0; sh_blocked[s] = 1'b0; sh_stack[s] = '0;
        end
        for (int l = 0; l < NLOCKS; l++) sh_held[l] = 1'b0;

        // Directed rows: after reset, a bad select, zero and full-scale stack pointers,
        // a full table, blocking, waking the running task and terminating a waiter.
        directed.push_back(row(REQ_SELECT,  16'h0000, 0, 1, 0, 0, ST_EMPTY));
        directed.push_back(row(REQ_SELECT,  16'hFFFF, 0, 1, 0, 0, ST_BAD));
        directed.push_back(row(REQ_RELEASE, 16'h0000, 3, 1, 0, 0, ST_OK));
        directed.push_back(row(REQ_ACQUIRE, 16'h0000, 2, 1, 0, 0, ST_OK));
        directed.push_back(row(REQ_ACQUIRE, 16'h0000, 2, 1, 0, 0, ST_BAD));
        directed.push_back(row(REQ_CREATE,  16'h0000, 0, 1, 0, 0, ST_OK));
        directed.push_back(row(REQ_CREATE,  16'hFFFF, 0, 1, 0, 1, ST_OK));
        directed.push_back(row(REQ_SELECT,  16'h0000, 0, 1, 0, 0, ST_OK));
        directed.push_back(row(REQ_SELECT,  16'hAAAA, 0, 1, 16'hFFFF, 1, ST_OK));
        directed.push_back(row(REQ_ACQUIRE, 16'h0000, 2, 1, 0, 0, ST_BLOCKED));
        directed.push_back(row(REQ_ACQUIRE, 16'h0000, 1, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_RELEASE, 16'h0000, 2, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_SELECT,  16'h5555, 0, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_ACQUIRE, 16'h0000, 1, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_SELECT,  16'h0000, 0, 0, 0, 0, ST_OK));
        for (int k = 0; k < 15; k++)
            directed.push_back(row(REQ_CREATE, 16'(k * 16'h1111), 0, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_CREATE,  16'h1234, 0, 1, 0, 0, ST_FULL));
        directed.push_back(row(REQ_RELEASE, 16'h0000, 1, 0, 0, 0, ST_OK));
        directed.push_back(row(REQ_RELEASE, 16'h0000, 0, 0, 0, 0, ST_OK));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_word(directed[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            w = random_request();
            send_word(w);
        end
        req_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Result sink: stalls on its own pattern, with one long hold-off.
    // ------------------------------------------------------------------
    int sink_cycle;
    int hold_off;

    initial begin
        res_ch.ready = 1'b0;
        sink_cycle   = 0;
        hold_off     = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            sink_cycle++;
            if (sink_cycle == 300) hold_off = 200;
            if (hold_off > 0) begin
                hold_off--;
                res_ch.ready <= 1'b0;
            end else if ((sink_cycle / 64) % 3 == 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome typed;
        logic     has_typed;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", res_ch.next_sp, 16'h0000);
            end else begin
                want      = pending_results.pop_front();
                has_typed = typed_flag.pop_front();
                typed     = typed_want.pop_front();
                if (res_ch.next_sp !== want.sp)
                    report_mismatch("next_sp", res_ch.next_sp, want.sp);
                if (res_ch.task_slot !== want.slot)
                    report_mismatch("task_slot", 16'(res_ch.task_slot), 16'(want.slot));
                if (res_ch.status !== want.status)
                    report_mismatch("status", 16'(res_ch.status), 16'(want.status));
                // Hand-typed rows also guard the shadow itself.
                if (has_typed && typed !== want)
                    report_mismatch("typed row", 16'(typed.status), 16'(want.status));
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
